// ----- hdl/wpn_pkg.sv -----
// Shared types, constants and the arctangent table for the waypoint heading navigator.
// Used by every module of the block; depends on nothing else.
package wpn_pkg;

    // Default build values for the top-level parameters.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int START_OFFSET_DEF = 15;

    // Number of entries in the arctangent table.
    localparam int ATAN_LEN = 24;

    // Field widths.
    localparam int POS_W     = 16;
    localparam int HEAD_W    = 9;
    localparam int REC_W     = 16;
    localparam int PAINT_W   = 8;
    localparam int GOAL_W    = 13;
    localparam int RADIUS_W  = 10;
    localparam int DIFF_W    = 18;  // target minus position, signed
    localparam int XY_W      = 28;  // CORDIC x/y datapath, signed
    localparam int ANG_W     = 27;  // 11.16 degree accumulator, signed
    localparam int ANG_FRAC  = 16;
    localparam int DEG_W     = ANG_W - ANG_FRAC;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_RADIUS = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [HEAD_W-1:0]   START_HEADING_RST  = 9'd0;
    localparam logic [RADIUS_W-1:0] ARRIVAL_RADIUS_RST = 10'd20;

    // Depth of the queue between classifier and bearing engine.
    localparam int QUEUE_DEPTH = 2;

    // 180 degrees in the 11.16 angle format.
    localparam logic signed [ANG_W-1:0] ANG_180 = 27'sd11796480;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [HEAD_W-1:0]        rel_heading;
        logic                     done;
        logic                     taken;
        logic                     drive_on;
        logic [PAINT_W-1:0]       paint;
        logic [GOAL_W-1:0]        goal_x;
        logic [GOAL_W-1:0]        goal_y;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_wpn_entry;

    // atan(2^-i) in degrees, 11.16 fixed point.
    function automatic logic signed [ANG_W-1:0] wpn_atan(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 27'sd2949120;
            1:       v = 27'sd1740967;
            2:       v = 27'sd919879;
            3:       v = 27'sd466945;
            4:       v = 27'sd234379;
            5:       v = 27'sd117266;
            6:       v = 27'sd58666;
            7:       v = 27'sd29335;
            8:       v = 27'sd14668;
            9:       v = 27'sd7334;
            10:      v = 27'sd3667;
            11:      v = 27'sd1833;
            12:      v = 27'sd917;
            13:      v = 27'sd458;
            14:      v = 27'sd229;
            15:      v = 27'sd115;
            16:      v = 27'sd57;
            17:      v = 27'sd29;
            18:      v = 27'sd14;
            19:      v = 27'sd7;
            20:      v = 27'sd4;
            21:      v = 27'sd2;
            22:      v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/waypoint_heading_navigator_top.sv -----
// Waypoint heading navigator. The front end takes one position fix per
// cycle while its two-entry queue has room, checks arrival and updates the
// target at once; the bearing engine then works one item at a time (a load
// step, the CORDIC steps until the residual is zero or the step count is
// reached, a check step, and the write of the output register once that
// register is free), so the sustained rate is set by the shared CORDIC step
// unit. A finished result waits in the output register while the next item
// is already being worked. Configuration writes are always ready and take
// effect the next cycle; write them only while idle.
//
// Top level; depends on wpn_pkg, wpn_front, wpn_queue and wpn_cordic.
module waypoint_heading_navigator_top #(
    parameter int CORDIC_STEPS = wpn_pkg::CORDIC_STEPS_DEF,
    parameter int START_OFFSET = wpn_pkg::START_OFFSET_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wpn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wpn_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x, pos_y, raw_heading, rec_x, rec_y, rec_paint (lowest bit first),
    // zero padded
    input  logic [wpn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,   // rec_final
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rel_heading, target_heading, drive_on, record_taken, paint_out,
    // finished, goal_x, goal_y (lowest bit first), zero padded
    output logic [wpn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import wpn_pkg::*;

    t_wpn_entry front_entry;
    t_wpn_entry queue_entry;
    logic       queue_full;
    logic       queue_empty;
    logic       queue_pop;
    logic       accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && !queue_full;

    // Classification and navigation state.
    wpn_front #(
        .START_OFFSET (START_OFFSET)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pos_x       (s_axis_tdata[15:0]),
        .i_pos_y       (s_axis_tdata[31:16]),
        .i_raw_heading (s_axis_tdata[40:32]),
        .i_rec_x       (s_axis_tdata[56:41]),
        .i_rec_y       (s_axis_tdata[72:57]),
        .i_rec_paint   (s_axis_tdata[80:73]),
        .i_rec_final   (s_axis_tlast),
        .o_entry       (front_entry)
    );

    // Decoupling queue.
    wpn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_entry),
        .i_pop   (queue_pop),
        .o_data  (queue_entry),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // Bearing engine and output register.
    wpn_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (queue_entry),
        .i_empty       (queue_empty),
        .o_pop         (queue_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- hdl/wpn_front.sv -----
// Front end: configuration registers, navigation state and per-item classification.
// Depends on wpn_pkg; feeds classified items into wpn_queue.
module wpn_front #(
    parameter int START_OFFSET = wpn_pkg::START_OFFSET_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    input  logic [wpn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wpn_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Accepted item fields
    input  logic                                i_accept,
    input  logic signed [wpn_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [wpn_pkg::POS_W-1:0]    i_pos_y,
    input  logic [wpn_pkg::HEAD_W-1:0]          i_raw_heading,
    input  logic [wpn_pkg::REC_W-1:0]           i_rec_x,
    input  logic [wpn_pkg::REC_W-1:0]           i_rec_y,
    input  logic [wpn_pkg::PAINT_W-1:0]         i_rec_paint,
    input  logic                                i_rec_final,
    // Classified item toward the queue
    output wpn_pkg::t_wpn_entry                 o_entry
);
    import wpn_pkg::*;

    logic [HEAD_W-1:0]   r_start_heading;
    logic [RADIUS_W-1:0] r_arrival_radius;
    logic [GOAL_W-1:0]   r_target_x;
    logic [GOAL_W-1:0]   r_target_y;
    logic                r_final_seen;
    logic                r_done;

    logic signed [HEAD_W+1:0] hd;
    logic signed [HEAD_W+1:0] rel;
    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] ey;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;
    logic                     near;
    logic                     n_done;
    logic                     take;
    logic [REC_W-1:0]         ry_adj;
    logic [GOAL_W-1:0]        n_target_x;
    logic [GOAL_W-1:0]        n_target_y;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_heading  <= START_HEADING_RST;
            r_arrival_radius <= ARRIVAL_RADIUS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_HEADING:  r_start_heading  <= i_cfg_data[HEAD_W-1:0];
                REG_ARRIVAL_RADIUS: r_arrival_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Relative heading, reduced into 0..359.
    always_comb begin
        hd = $signed({2'b00, i_raw_heading}) - $signed({2'b00, r_start_heading});
        if (hd >= 11'sd360) begin
            rel = hd - 11'sd360;
        end else if (hd < -11'sd360) begin
            rel = hd + 11'sd720;
        end else if (hd < 11'sd0) begin
            rel = hd + 11'sd360;
        end else begin
            rel = hd;
        end
    end

    // Arrival test against the current target, per axis.
    always_comb begin
        ex   = DIFF_W'(i_pos_x) - $signed({5'b0, r_target_x});
        ey   = DIFF_W'(i_pos_y) - $signed({5'b0, r_target_y});
        ax   = ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
        ay   = ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
        near = (ax < {8'b0, r_arrival_radius}) && (ay < {8'b0, r_arrival_radius});
    end

    // Stop on the last target, otherwise take the record when near.
    always_comb begin
        n_done     = r_done | (near & r_final_seen);
        take       = near & ~n_done;
        ry_adj     = 16'd1000 - i_rec_y;
        n_target_x = take ? i_rec_x[REC_W-1:3] : r_target_x;
        n_target_y = take ? ry_adj[REC_W-1:3]  : r_target_y;
    end

    // Classified item toward the bearing engine.
    always_comb begin
        o_entry.rel_heading = rel[HEAD_W-1:0];
        o_entry.done        = n_done;
        o_entry.taken       = take;
        o_entry.drive_on    = ~n_done & ~(take & i_rec_final);
        o_entry.paint       = take ? i_rec_paint : '0;
        o_entry.goal_x      = n_target_x;
        o_entry.goal_y      = n_target_y;
        o_entry.dx          = $signed({5'b0, n_target_x}) - DIFF_W'(i_pos_x);
        o_entry.dy          = $signed({5'b0, n_target_y}) - DIFF_W'(i_pos_y);
    end

    // Navigation state, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x   <= GOAL_W'(START_OFFSET);
            r_target_y   <= GOAL_W'(START_OFFSET);
            r_final_seen <= 1'b0;
            r_done       <= 1'b0;
        end else if (i_accept) begin
            r_done     <= n_done;
            r_target_x <= n_target_x;
            r_target_y <= n_target_y;
            if (take) begin
                r_final_seen <= i_rec_final;
            end
        end
    end

endmodule

// ----- hdl/wpn_queue.sv -----
// Short queue of classified items between the front end and the bearing engine.
// Depends on wpn_pkg for the item type and the queue depth.
module wpn_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  wpn_pkg::t_wpn_entry  i_data,
    input  logic                 i_pop,
    output wpn_pkg::t_wpn_entry  o_data,
    output logic                 o_full,
    output logic                 o_empty
);
    import wpn_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_wpn_entry       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/wpn_cordic.sv -----
// Back end: iterative vectoring CORDIC for the bearing and the output register.
// Depends on wpn_pkg; takes items from wpn_queue.
module wpn_cordic #(
    parameter int CORDIC_STEPS = wpn_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wpn_pkg::t_wpn_entry                  i_entry,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // rel_heading, target_heading, drive_on, record_taken, paint_out,
    // finished, goal_x, goal_y (lowest bit first), zero padded
    output logic [wpn_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import wpn_pkg::*;

    localparam int IT_W = $clog2(CORDIC_STEPS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]              r_state;
    t_wpn_entry              r_ent;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [IT_W-1:0]         r_iter;
    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data;

    logic signed [XY_W-1:0]  x0;
    logic signed [XY_W-1:0]  y0;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic                    iter_end;
    logic signed [ANG_W-1:0] z_mag;
    logic signed [DEG_W-1:0] deg;
    logic signed [DEG_W-1:0] deg_wrap;
    logic [HEAD_W-1:0]       target_heading;
    logic                    out_free;

    assign o_pop         = (r_state == ST_IDLE) && !i_empty;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign out_free      = !r_m_valid || m_axis_tready;

    // Scaled start vector and one shift-add step.
    always_comb begin
        x0       = {{(XY_W-DIFF_W-8){i_entry.dx[DIFF_W-1]}}, i_entry.dx, 8'b0};
        y0       = {{(XY_W-DIFF_W-8){i_entry.dy[DIFF_W-1]}}, i_entry.dy, 8'b0};
        xs       = r_x >>> r_iter;
        ys       = r_y >>> r_iter;
        iter_end = (r_iter == IT_W'(CORDIC_STEPS)) || (r_y == '0);
    end

    // Angle truncated toward zero, wrapped, and turned into the target heading.
    always_comb begin
        z_mag    = r_z[ANG_W-1] ? -r_z : r_z;
        deg      = r_z[ANG_W-1] ? -$signed(DEG_W'(z_mag >>> ANG_FRAC))
                                :  $signed(DEG_W'(z_mag >>> ANG_FRAC));
        deg_wrap = (deg < 0) ? deg + 11'sd360 : deg;
        target_heading = r_ent.done ? '0 : HEAD_W'(11'sd360 - deg_wrap);
    end

    // Sequencer and CORDIC datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (iter_end) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent  <= i_entry;
            r_iter <= '0;
            if (i_entry.dy == '0) begin
                // Horizontal vector: bearing is 0 or 180 without iterating.
                r_x <= x0;
                r_y <= '0;
                r_z <= i_entry.dx[DIFF_W-1] ? ANG_180 : '0;
            end else if (i_entry.dx[DIFF_W-1]) begin
                // Left half plane: rotate by 180 degrees first.
                r_x <= -x0;
                r_y <= -y0;
                r_z <= i_entry.dy[DIFF_W-1] ? -ANG_180 : ANG_180;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_state == ST_RUN && !iter_end) begin
            r_iter <= r_iter + 1'b1;
            if (!r_y[XY_W-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + wpn_atan(int'(r_iter));
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - wpn_atan(int'(r_iter));
            end
        end
    end

    // Output register; the next item can run while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_m_data <= {1'b0, r_ent.goal_y, r_ent.goal_x, r_ent.done, r_ent.paint,
                         r_ent.taken, r_ent.drive_on, target_heading, r_ent.rel_heading};
        end
    end

endmodule

// ----- hdl/wpn_checker.sv -----
// Port-level checks on the navigator's result stream, and the bind that attaches them.
// Depends on wpn_pkg and on waypoint_heading_navigator_top.
module wpn_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [wpn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import wpn_pkg::*;

    logic r_fin_seen;
    logic out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Remember that a finished item has gone out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_seen <= 1'b0;
        end else if (out_acc && m_axis_tdata[28]) begin
            r_fin_seen <= 1'b1;
        end
    end

    // Once finished, every later item stays finished.
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_fin_seen) |-> m_axis_tdata[28])
        else $error("finished dropped after the last target");

    // A finished item neither drives, takes a record nor reports a bearing.
    a_fin_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[28]) |->
        (!m_axis_tdata[18] && !m_axis_tdata[19] && m_axis_tdata[17:9] == 9'd0
         && m_axis_tdata[27:20] == 8'd0))
        else $error("finished item carries drive, take or bearing");

    // Paint only comes with a taken record; headings stay in range.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        ((m_axis_tdata[19] || m_axis_tdata[27:20] == 8'd0)
         && m_axis_tdata[8:0] < 9'd360 && m_axis_tdata[17:9] <= 9'd360))
        else $error("result fields out of range");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind waypoint_heading_navigator_top wpn_checker u_wpn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_waypoint_heading_navigator_top.sv -----
// Self-checking testbench for the waypoint heading navigator: a directed table, then
// random position fixes, mostly aimed at the current target, checked against a built-in predictor.
// Depends on wpn_pkg and waypoint_heading_navigator_top.
module tb_waypoint_heading_navigator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpn_pkg::*;

    localparam int NAV_STEPS     = CORDIC_STEPS_DEF;
    localparam int NAV_OFFSET    = START_OFFSET_DEF;
    localparam int SETTLE_CYCLES = NAV_STEPS + 8;
    localparam int PHASE_ITEMS   = 425;

    // Index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    // atan(2^-i) in degrees, 16.16 fixed point.
    localparam longint ARCTAN_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // One position fix with the next waypoint record; last listed field in the low bits.
    typedef struct packed {
        logic                     rec_final;
        logic [PAINT_W-1:0]       rec_paint;
        logic [REC_W-1:0]         rec_y;
        logic [REC_W-1:0]         rec_x;
        logic [HEAD_W-1:0]        raw_heading;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } t_fix;

    // One navigation report; last listed field in the low bits.
    typedef struct packed {
        logic [GOAL_W-1:0]  goal_y;
        logic [GOAL_W-1:0]  goal_x;
        logic               finished;
        logic [PAINT_W-1:0] paint_out;
        logic               record_taken;
        logic               drive_on;
        logic [HEAD_W-1:0]  target_heading;
        logic [HEAD_W-1:0]  rel_heading;
    } t_nav_result;

    typedef enum {ROW_FIX, ROW_CFG} t_row_kind;
    typedef enum {AIM_INSIDE, AIM_EDGE, AIM_ANYWHERE} t_aim;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        t_fix                   fix;
        bit                     typed;
        t_nav_result            want;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // Predictor state and its copy of the configuration.
    logic [GOAL_W-1:0]   nav_goal_x = GOAL_W'(NAV_OFFSET);
    logic [GOAL_W-1:0]   nav_goal_y = GOAL_W'(NAV_OFFSET);
    bit                  nav_last_pending = 1'b0;
    bit                  nav_finished = 1'b0;
    logic [HEAD_W-1:0]   cur_start_heading = START_HEADING_RST;
    logic [RADIUS_W-1:0] cur_radius = ARRIVAL_RADIUS_RST;

    t_nav_result expected_results[$];
    t_plan_row   opening_plan[$];
    int          fail_count = 0;
    bit          no_gaps = 1'b0;

    waypoint_heading_navigator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Whole-degree bearing of (dx, dy), truncated toward zero, -180..180.
    function automatic int bearing_degrees(longint dx, longint dy);
        longint vx, vy, ang, base, sx, sy;
        int     i;
        vx = dx * 256;
        vy = dy * 256;
        ang = 0;
        base = 0;
        if (dy == 0) begin
            return (dx >= 0) ? 0 : 180;
        end
        // Left half plane: turn by 180 degrees first.
        if (vx < 0) begin
            base = (vy >= 0) ? 180 * 65536 : -180 * 65536;
            vx = -vx;
            vy = -vy;
        end
        for (i = 0; i < NAV_STEPS && i < 24; i++) begin
            if (vy == 0) begin
                break;
            end
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
                vx = vx + sy;
                vy = vy - sx;
                ang = ang + ARCTAN_Q16[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                ang = ang - ARCTAN_Q16[i];
            end
        end
        ang = ang + base;
        if (ang >= 0) begin
            return int'(ang >>> 16);
        end
        return -int'((-ang) >>> 16);
    endfunction

    // True when the fix lies strictly inside the radius of the target on both axes.
    function automatic bit fix_is_near(t_fix f);
        int ax, ay;
        ax = int'(f.pos_x) - int'(nav_goal_x);
        ay = int'(f.pos_y) - int'(nav_goal_y);
        if (ax < 0) begin
            ax = -ax;
        end
        if (ay < 0) begin
            ay = -ay;
        end
        return (ax < int'(cur_radius)) && (ay < int'(cur_radius));
    endfunction

    // Applies one fix to the predictor state and returns the report it should cause.
    function automatic t_nav_result advance_navigator(t_fix f);
        t_nav_result     r;
        int              rel, bearing;
        bit              near;
        logic [REC_W-1:0] flipped_y;
        r = '0;
        r.drive_on = 1'b1;
        rel = (int'(f.raw_heading) - int'(cur_start_heading)) % 360;
        if (rel < 0) begin
            rel += 360;
        end
        r.rel_heading = HEAD_W'(rel);
        near = fix_is_near(f);
        if (!nav_finished && near && nav_last_pending) begin
            nav_finished = 1'b1;
        end
        if (nav_finished) begin
            r.drive_on = 1'b0;
        end else begin
            // Take the record as the new target.
            if (near) begin
                flipped_y = REC_W'(1000) - f.rec_y;
                nav_goal_x = f.rec_x[REC_W-1:3];
                nav_goal_y = flipped_y[REC_W-1:3];
                nav_last_pending = f.rec_final;
                r.record_taken = 1'b1;
                r.paint_out = f.rec_paint;
                r.drive_on = !f.rec_final;
            end
            bearing = bearing_degrees(longint'(nav_goal_x) - longint'(f.pos_x),
                                      longint'(nav_goal_y) - longint'(f.pos_y));
            if (bearing < 0) begin
                bearing += 360;
            end
            r.target_heading = HEAD_W'(360 - bearing);
        end
        r.finished = nav_finished;
        r.goal_x = nav_goal_x;
        r.goal_y = nav_goal_y;
        return r;
    endfunction

    // Random fix near the target or anywhere; final flag only if allowed when near, else random.
    function automatic t_fix random_fix(t_aim aim, bit allow_final);
        t_fix f;
        int   span, r, px, py;
        r = int'(cur_radius);
        span = r - 1;
        px = int'(nav_goal_x) + int'($urandom_range(0, 2 * span)) - span;
        py = int'(nav_goal_y) + int'($urandom_range(0, 2 * span)) - span;
        case (aim)
            AIM_EDGE: begin
                // Exactly on the radius on one axis, which does not count as arrived.
                if ($urandom_range(0, 1)) begin
                    px = int'(nav_goal_x) + ($urandom_range(0, 1) ? r : -r);
                end else begin
                    py = int'(nav_goal_y) + ($urandom_range(0, 1) ? r : -r);
                end
            end
            AIM_ANYWHERE: begin
                px = int'($urandom);
                py = int'($urandom);
            end
            default: begin
            end
        endcase
        f.pos_x = px[POS_W-1:0];
        f.pos_y = py[POS_W-1:0];
        f.raw_heading = HEAD_W'($urandom_range(0, 511));
        f.rec_x = REC_W'($urandom);
        f.rec_y = REC_W'($urandom);
        f.rec_paint = PAINT_W'($urandom);
        f.rec_final = 1'b0;
        f.rec_final = fix_is_near(f) ? allow_final : 1'($urandom_range(0, 1));
        return f;
    endfunction

    function automatic t_plan_row fix_row(int px, int py, int raw, int rx, int ry,
                                          int paint, bit fin);
        t_plan_row row;
        row = '{kind: ROW_FIX, reg_index: '0, reg_value: '0, fix: '0, typed: 1'b0,
                want: '0};
        row.fix.pos_x = px[POS_W-1:0];
        row.fix.pos_y = py[POS_W-1:0];
        row.fix.raw_heading = raw[HEAD_W-1:0];
        row.fix.rec_x = rx[REC_W-1:0];
        row.fix.rec_y = ry[REC_W-1:0];
        row.fix.rec_paint = paint[PAINT_W-1:0];
        row.fix.rec_final = fin;
        return row;
    endfunction

    function automatic t_plan_row checked_row(t_plan_row row, t_nav_result want);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] idx, int value);
        t_plan_row row;
        row = '{kind: ROW_CFG, reg_index: idx, reg_value: value[CFG_DATA_W-1:0],
                fix: '0, typed: 1'b0, want: '0};
        return row;
    endfunction

    // Predicts one fix, queues its expected report and hands it over the input stream.
    task automatic issue_fix(t_fix f, bit typed, t_nav_result typed_want);
        t_nav_result model_out;
        model_out = advance_navigator(f);
        expected_results.push_back(typed ? typed_want : model_out);
        while (!no_gaps && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(f[$bits(t_fix)-2:0]);
        s_axis_tlast <= f.rec_final;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Lets every outstanding report drain, then the engine settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_START_HEADING) begin
            cur_start_heading = value[HEAD_W-1:0];
        end else if (idx == REG_ARRIVAL_RADIUS) begin
            cur_radius = value[RADIUS_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Output side: random back-pressure and comparison with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_nav_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_nav_result)-1:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("rel_heading", want.rel_heading, got.rel_heading);
                check_field("target_heading", want.target_heading, got.target_heading);
                check_field("drive_on", want.drive_on, got.drive_on);
                check_field("record_taken", want.record_taken, got.record_taken);
                check_field("paint_out", want.paint_out, got.paint_out);
                check_field("finished", want.finished, got.finished);
                check_field("goal_x", want.goal_x, got.goal_x);
                check_field("goal_y", want.goal_y, got.goal_y);
            end
        end
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 14);
    end

    // Main sequence: reset, directed table, random phases, closing run to the last target.
    initial begin
        int phase, roll;
        t_aim aim;
        // Fix on the target after reset whose record puts the target on the fix.
        opening_plan.push_back(checked_row(fix_row(15, 15, 0, 120, 880, 255, 0),
            '{rel_heading: 0, target_heading: 360, drive_on: 1, record_taken: 1,
              paint_out: 255, finished: 0, goal_x: 15, goal_y: 15}));
        // Far fix due left of the target; the final flag is ignored without a take.
        opening_plan.push_back(checked_row(fix_row(-32768, 15, 359, 65535, 65535, 170, 1),
            '{rel_heading: 359, target_heading: 360, drive_on: 1, record_taken: 0,
              paint_out: 0, finished: 0, goal_x: 15, goal_y: 15}));
        // Target due left, raw heading beyond 359.
        opening_plan.push_back(checked_row(fix_row(32767, 15, 511, 0, 0, 0, 0),
            '{rel_heading: 151, target_heading: 180, drive_on: 1, record_taken: 0,
              paint_out: 0, finished: 0, goal_x: 15, goal_y: 15}));
        opening_plan.push_back(fix_row(15, 32767, 360, 0, 65535, 85, 1));
        opening_plan.push_back(fix_row(15, -32768, 256, 65535, 0, 0, 0));
        // Takes at the largest target values, then back to the origin.
        opening_plan.push_back(fix_row(34, -4, 1, 65535, 1001, 1, 0));
        opening_plan.push_back(fix_row(8191, 8191, 180, 0, 1000, 128, 0));
        opening_plan.push_back(cfg_row(REG_START_HEADING, 359));
        opening_plan.push_back(cfg_row(REG_ARRIVAL_RADIUS, 1));
        opening_plan.push_back(fix_row(0, 0, 0, 8, 992, 64, 0));
        opening_plan.push_back(fix_row(0, 1, 358, 4660, 22136, 2, 1));
        opening_plan.push_back(cfg_row(REG_ARRIVAL_RADIUS, 1023));
        opening_plan.push_back(cfg_row(REG_SPARE, 1023));
        opening_plan.push_back(fix_row(1023, -1021, 100, 40, 960, 127, 0));
        opening_plan.push_back(fix_row(-1, -1, 1, 65535, 65535, 255, 0));
        opening_plan.push_back(cfg_row(REG_START_HEADING, 0));
        opening_plan.push_back(cfg_row(REG_ARRIVAL_RADIUS, 20));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_plan[k]) begin
            if (opening_plan[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(opening_plan[k].reg_index, opening_plan[k].reg_value);
            end else begin
                issue_fix(opening_plan[k].fix, opening_plan[k].typed, opening_plan[k].want);
            end
        end

        // Random phases, each under its own settings; phase two runs without gaps.
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_reg(REG_START_HEADING, CFG_DATA_W'($urandom_range(0, phase == 3 ? 511 : 359)));
            case (phase)
                0: write_reg(REG_ARRIVAL_RADIUS, CFG_DATA_W'($urandom_range(1, 8)));
                1: write_reg(REG_ARRIVAL_RADIUS, CFG_DATA_W'($urandom_range(9, 64)));
                2: write_reg(REG_ARRIVAL_RADIUS, CFG_DATA_W'(1023));
                default: write_reg(REG_ARRIVAL_RADIUS, CFG_DATA_W'($urandom_range(1, 1023)));
            endcase
            no_gaps = (phase == 2);
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                aim = (roll < 60) ? AIM_INSIDE : (roll < 75) ? AIM_EDGE : AIM_ANYWHERE;
                issue_fix(random_fix(aim, 1'b0), 1'b0, '0);
            end
        end
        no_gaps = 1'b0;

        // Take a final record, wander, reach it, then keep sending to a finished block.
        issue_fix(random_fix(AIM_INSIDE, 1'b1), 1'b0, '0);
        repeat (3) issue_fix(random_fix(AIM_ANYWHERE, 1'b0), 1'b0, '0);
        issue_fix(random_fix(AIM_INSIDE, 1'b0), 1'b0, '0);
        repeat (2) issue_fix(random_fix(AIM_INSIDE, 1'b1), 1'b0, '0);
        repeat (2) issue_fix(random_fix(AIM_ANYWHERE, 1'b1), 1'b0, '0);

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/wpn_pkg.sv
hdl/wpn_front.sv
hdl/wpn_queue.sv
hdl/wpn_cordic.sv
hdl/waypoint_heading_navigator_top.sv
hdl/wpn_checker.sv
tb/sv/tb_waypoint_heading_navigator_top.sv
